// ===== design/artm_pkg.sv =====
// ----------------------------------------------------------------------------
// artm_pkg
// Shared types and constants of the alert rule threat matcher.
// ----------------------------------------------------------------------------
package artm_pkg;

  localparam int MAX_RULES = 8;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int VAL_W     = 24;

  // most negative code stands for a value that is not available
  localparam logic signed [VAL_W-1:0] NOT_AVAIL = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_DIST_IN  = 3'd1,
    KIND_DIST_OUT = 3'd2,
    KIND_SPEED    = 3'd3,
    KIND_ACCEL    = 3'd4,
    KIND_DECEL    = 3'd5,
    KIND_TTC      = 3'd6
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              receiver;
    logic [7:0]              channels;
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;
    logic [2:0]              level;
  } rule_t;

  typedef struct packed {
    logic [7:0]              receiver;
    logic [7:0]              channels;
    logic signed [VAL_W-1:0] distance;
    logic signed [VAL_W-1:0] velocity;
    logic signed [VAL_W-1:0] acceleration;
    logic signed [VAL_W-1:0] decel_to_stop;
    logic signed [VAL_W-1:0] time_to_collision;
  } obj_t;

  localparam int RULE_W = $bits(rule_t);

endpackage

// ===== design/artm_ram.sv =====
// ----------------------------------------------------------------------------
// artm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module artm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/artm_cmp.sv =====
// ----------------------------------------------------------------------------
// artm_cmp
// Shared rule compare unit: receiver and channel match plus one range test.
// ----------------------------------------------------------------------------
module artm_cmp (
  input  artm_pkg::rule_t rule,
  input  artm_pkg::obj_t  obj,
  output logic            fire
);
  import artm_pkg::*;

  logic                    match;
  logic signed [VAL_W-1:0] val;
  logic                    need_avail;
  logic                    invert;
  logic                    valid_kind;
  logic                    in_range;

  assign match = (rule.receiver == obj.receiver) && (|(rule.channels & obj.channels));

  always_comb begin
    val        = obj.distance;
    need_avail = 1'b0;
    invert     = 1'b0;
    valid_kind = 1'b1;
    unique case (rule.kind)
      KIND_DIST_IN: begin
        val = obj.distance;
      end
      KIND_DIST_OUT: begin
        val    = obj.distance;
        invert = 1'b1;
      end
      KIND_SPEED: begin
        val        = obj.velocity;
        need_avail = 1'b1;
      end
      KIND_ACCEL: begin
        val        = obj.acceleration;
        need_avail = 1'b1;
      end
      KIND_DECEL: begin
        val        = obj.decel_to_stop;
        need_avail = 1'b1;
      end
      KIND_TTC: begin
        val        = obj.time_to_collision;
        need_avail = 1'b1;
      end
      default: begin
        valid_kind = 1'b0;
      end
    endcase
  end

  // for speed, accel, decel and TTC kinds the not available code fails the test outright
  assign in_range = (val >= rule.lower) && (val <= rule.upper) &&
                    !(need_avail && (val == NOT_AVAIL));

  assign fire = match && valid_kind && (in_range ^ invert);

endmodule

// ===== design/alert_rule_threat_matcher.sv =====
// ----------------------------------------------------------------------------
// alert_rule_threat_matcher
// Rule table with a sequencer that scans it through one shared compare unit.
// ----------------------------------------------------------------------------
// append, clear and unused codes: done rises in the cycle after the request is taken
// evaluate: done follows the scan of every stored rule, one rule per cycle,
//   paced by the single read port of the rule RAM and the shared compare unit
// evaluate holds busy up to the done cycle; other codes never raise busy
// the done strobe cannot be stalled by the receiver
// rst clears the rule count and control state; table entries are not cleared
module alert_rule_threat_matcher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [2:0]                         rule_type,
  input  logic [2:0]                         rule_threat,
  input  logic signed [artm_pkg::VAL_W-1:0]  rule_low,
  input  logic signed [artm_pkg::VAL_W-1:0]  rule_high,
  input  logic [7:0]                         receiver_id,
  input  logic [7:0]                         channel_mask,
  input  logic signed [artm_pkg::VAL_W-1:0]  distance,
  input  logic signed [artm_pkg::VAL_W-1:0]  velocity,
  input  logic signed [artm_pkg::VAL_W-1:0]  acceleration,
  input  logic signed [artm_pkg::VAL_W-1:0]  decel_to_stop,
  input  logic signed [artm_pkg::VAL_W-1:0]  time_to_collision,
  output logic                               done,
  output logic [2:0]                         threat_level,
  output logic                               status
);
  import artm_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  rule_count, rule_count_next;
  logic [CNT_W-1:0]  issue, issue_next;
  logic              rd_valid, rd_valid_next;
  logic [2:0]        level, level_next;
  obj_t              obj, obj_next;
  logic              done_next;
  logic [2:0]        threat_level_next;
  logic              status_next;

  logic              accept;
  logic              table_full;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RULE_W-1:0] ram_wdata;
  logic [RULE_W-1:0] ram_rdata;
  rule_t             rule_new;
  rule_t             rule_rd;
  logic              fire;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign table_full = (rule_count == CNT_W'(MAX_RULES));

  always_comb begin
    rule_new.kind     = kind_t'(rule_type);
    rule_new.receiver = receiver_id;
    rule_new.channels = channel_mask;
    rule_new.lower    = rule_low;
    rule_new.upper    = rule_high;
    rule_new.level    = rule_threat;
  end

  assign ram_wdata = rule_new;
  assign ram_we    = accept && (operation == OP_APPEND) && !table_full;
  // entry 0 is read on the request cycle so the scan starts right away
  assign ram_raddr = (state == ST_IDLE) ? '0 : issue[IDX_W-1:0];
  assign rule_rd   = rule_t'(ram_rdata);

  artm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rule_count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  artm_cmp u_cmp (
    .rule (rule_rd),
    .obj  (obj),
    .fire (fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rule_count   <= '0;
      issue        <= '0;
      rd_valid     <= 1'b0;
      level        <= '0;
      done         <= 1'b0;
      threat_level <= '0;
      status       <= 1'b0;
    end else begin
      state        <= state_next;
      rule_count   <= rule_count_next;
      issue        <= issue_next;
      rd_valid     <= rd_valid_next;
      level        <= level_next;
      done         <= done_next;
      threat_level <= threat_level_next;
      status       <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    obj <= obj_next;
  end

  always_comb begin
    state_next        = state;
    rule_count_next   = rule_count;
    issue_next        = issue;
    rd_valid_next     = rd_valid;
    level_next        = level;
    obj_next          = obj;
    done_next         = 1'b0;
    threat_level_next = '0;
    status_next       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_EVAL: begin
              obj_next.receiver          = receiver_id;
              obj_next.channels          = channel_mask;
              obj_next.distance          = distance;
              obj_next.velocity          = velocity;
              obj_next.acceleration      = acceleration;
              obj_next.decel_to_stop     = decel_to_stop;
              obj_next.time_to_collision = time_to_collision;
              level_next    = '0;
              issue_next    = CNT_W'(1);
              rd_valid_next = (rule_count != '0);
              state_next    = ST_SCAN;
            end
            OP_APPEND: begin
              if (table_full) begin
                status_next = 1'b1;
              end else begin
                rule_count_next = rule_count + CNT_W'(1);
              end
              done_next = 1'b1;
            end
            OP_CLEAR: begin
              rule_count_next = '0;
              done_next       = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_valid) begin
          if (fire && (rule_rd.level > level)) begin
            level_next = rule_rd.level;
          end
          rd_valid_next = (issue < rule_count);
          if (issue < rule_count) begin
            issue_next = issue + CNT_W'(1);
          end
        end else begin
          // every stored rule has been through the compare unit
          done_next         = 1'b1;
          threat_level_next = level;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES))
    else $error("rule count above table size");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while still scanning");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    status |-> done)
    else $error("status without done");

  a_level_done: assert property (@(posedge clk) disable iff (rst)
    (threat_level != '0) |-> (done && !status))
    else $error("threat level outside an evaluate result");

  a_rd_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_SCAN))
    else $error("rule read valid outside scan");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_APPEND) && table_full) |=> (status && done))
    else $error("append to full table not refused");
`endif

endmodule

// ===== tb/artm_threat_checker.sv =====
// ----------------------------------------------------------------------------
// artm_threat_checker
// Watches the request and result channels of the alert rule threat matcher,
// keeps its own copy of the rule table and checks every result in order.
// ----------------------------------------------------------------------------
module artm_threat_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [2:0]                         rule_type,
  input  logic [2:0]                         rule_threat,
  input  logic signed [artm_pkg::VAL_W-1:0]  rule_low,
  input  logic signed [artm_pkg::VAL_W-1:0]  rule_high,
  input  logic [7:0]                         receiver_id,
  input  logic [7:0]                         channel_mask,
  input  logic signed [artm_pkg::VAL_W-1:0]  distance,
  input  logic signed [artm_pkg::VAL_W-1:0]  velocity,
  input  logic signed [artm_pkg::VAL_W-1:0]  acceleration,
  input  logic signed [artm_pkg::VAL_W-1:0]  decel_to_stop,
  input  logic signed [artm_pkg::VAL_W-1:0]  time_to_collision,
  input  logic                               done,
  input  logic [2:0]                         threat_level,
  input  logic                               status,
  output int                                 fails,
  output int                                 pending
);
  import artm_pkg::*;

  typedef struct {
    logic [2:0]              kind;
    logic [7:0]              rcv;
    logic [7:0]              chans;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [2:0]              level;
  } stored_rule_t;

  typedef struct {
    logic [2:0] level;
    logic       refused;
  } threat_answer_t;

  stored_rule_t   rule_table [MAX_RULES];
  int unsigned    rules_held = 0;
  threat_answer_t answer_fifo [int];
  int             wr_ptr = 0;
  int             rd_ptr = 0;
  int             miss_count = 0;
  int             backlog = 0;

  assign fails   = miss_count;
  assign pending = backlog;

  task automatic flag(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    miss_count++;
  endtask

  function automatic bit in_bounds(logic signed [VAL_W-1:0] v,
                                   logic signed [VAL_W-1:0] lo,
                                   logic signed [VAL_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // not-available code never fires
  function automatic bit known_in_bounds(logic signed [VAL_W-1:0] v,
                                         logic signed [VAL_W-1:0] lo,
                                         logic signed [VAL_W-1:0] hi);
    return (v != NOT_AVAIL) && in_bounds(v, lo, hi);
  endfunction

  function automatic threat_answer_t apply_request();
    threat_answer_t res;
    bit             fired;
    res.level   = 3'd0;
    res.refused = 1'b0;
    case (operation)
      OP_EVAL: begin
        for (int i = 0; i < rules_held; i++) begin
          if (rule_table[i].rcv == receiver_id &&
              (rule_table[i].chans & channel_mask) != 8'd0) begin
            case (rule_table[i].kind)
              KIND_DIST_IN:  fired = in_bounds(distance, rule_table[i].lo, rule_table[i].hi);
              KIND_DIST_OUT: fired = !in_bounds(distance, rule_table[i].lo, rule_table[i].hi);
              KIND_SPEED:    fired = known_in_bounds(velocity, rule_table[i].lo,
                                                     rule_table[i].hi);
              KIND_ACCEL:    fired = known_in_bounds(acceleration, rule_table[i].lo,
                                                     rule_table[i].hi);
              KIND_DECEL:    fired = known_in_bounds(decel_to_stop, rule_table[i].lo,
                                                     rule_table[i].hi);
              KIND_TTC:      fired = known_in_bounds(time_to_collision, rule_table[i].lo,
                                                     rule_table[i].hi);
              default:       fired = 1'b0;
            endcase
            if (fired && rule_table[i].level > res.level) res.level = rule_table[i].level;
          end
        end
      end
      OP_APPEND: begin
        if (rules_held >= MAX_RULES) begin
          res.refused = 1'b1;
        end else begin
          rule_table[rules_held] = '{kind: rule_type, rcv: receiver_id, chans: channel_mask,
                                     lo: rule_low, hi: rule_high, level: rule_threat};
          rules_held++;
        end
      end
      OP_CLEAR: begin
        rules_held = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    threat_answer_t want;
    if (!rst) begin
      // result of an older request may leave at the edge that takes a new one
      if (done) begin
        if (wr_ptr == rd_ptr) begin
          flag("result strobe with no request outstanding");
        end else begin
          want = answer_fifo[rd_ptr];
          answer_fifo.delete(rd_ptr);
          rd_ptr++;
          if (threat_level !== want.level)
            flag($sformatf("threat_level %0d, expected %0d", threat_level, want.level));
          if (status !== want.refused)
            flag($sformatf("status %0b, expected %0b", status, want.refused));
        end
      end
      if (start && !busy) begin
        answer_fifo[wr_ptr] = apply_request();
        wr_ptr++;
      end
    end
    backlog <= wr_ptr - rd_ptr;
  end

endmodule

// ===== tb/tb_alert_rule_threat_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_alert_rule_threat_matcher
// Drives directed and random rule table sequences into the threat matcher;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_alert_rule_threat_matcher;
  import artm_pkg::*;

  localparam int         LIMIT       = 200000;
  localparam int         RAND_ITEMS  = 1500;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] KIND_SEVEN  = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    logic [1:0]              op;
    logic [2:0]              kind;
    logic [2:0]              threat;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [7:0]              rcv;
    logic [7:0]              mask;
    logic signed [VAL_W-1:0] obj_dist;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] acc;
    logic signed [VAL_W-1:0] dec;
    logic signed [VAL_W-1:0] ttc;
  } request_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              operation = OP_EVAL;
  logic [2:0]              rule_type = '0;
  logic [2:0]              rule_threat = '0;
  logic signed [VAL_W-1:0] rule_low = '0;
  logic signed [VAL_W-1:0] rule_high = '0;
  logic [7:0]              receiver_id = '0;
  logic [7:0]              channel_mask = '0;
  logic signed [VAL_W-1:0] distance = '0;
  logic signed [VAL_W-1:0] velocity = '0;
  logic signed [VAL_W-1:0] acceleration = '0;
  logic signed [VAL_W-1:0] decel_to_stop = '0;
  logic signed [VAL_W-1:0] time_to_collision = '0;
  logic                    done;
  logic [2:0]              threat_level;
  logic                    status;
  int                      fails;
  int                      pending;
  int                      cycles = 0;
  int                      sent = 0;
  bit                      calm = 1'b0;

  alert_rule_threat_matcher u_dut (.*);

  artm_threat_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] num(int v);
    return VAL_W'(v);
  endfunction

  // small values half of the time so bounds and object values meet often
  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(9))
      0:       return NOT_AVAIL;
      1:       return VAL_MAX;
      2:       return NOT_AVAIL + VAL_W'(1);
      3, 4:    return VAL_W'($urandom);
      default: return VAL_W'(int'($urandom_range(96)) - 48);
    endcase
  endfunction

  function automatic request_t blank(logic [1:0] op);
    request_t r;
    r = '{op: op, kind: '0, threat: '0, lo: '0, hi: '0, rcv: '0, mask: '0,
          obj_dist: '0, vel: '0, acc: '0, dec: '0, ttc: '0};
    return r;
  endfunction

  function automatic request_t rule_req(logic [2:0] kind, logic [2:0] threat,
                                        logic signed [VAL_W-1:0] lo,
                                        logic signed [VAL_W-1:0] hi,
                                        logic [7:0] rcv, logic [7:0] mask);
    request_t r;
    r = blank(OP_APPEND);
    r.kind = kind; r.threat = threat; r.lo = lo; r.hi = hi; r.rcv = rcv; r.mask = mask;
    return r;
  endfunction

  function automatic request_t object_req(logic [7:0] rcv, logic [7:0] mask,
                                          logic signed [VAL_W-1:0] obj_dist,
                                          logic signed [VAL_W-1:0] vel,
                                          logic signed [VAL_W-1:0] acc,
                                          logic signed [VAL_W-1:0] dec,
                                          logic signed [VAL_W-1:0] ttc);
    request_t r;
    r = blank(OP_EVAL);
    r.rcv = rcv; r.mask = mask; r.obj_dist = obj_dist; r.vel = vel; r.acc = acc;
    r.dec = dec; r.ttc = ttc;
    return r;
  endfunction

  function automatic request_t noise_req();
    request_t r;
    r = '{op: 2'($urandom_range(3)), kind: 3'($urandom_range(7)),
          threat: 3'($urandom_range(7)), lo: VAL_W'($urandom), hi: VAL_W'($urandom),
          rcv: 8'($urandom_range(255)), mask: 8'($urandom_range(255)),
          obj_dist: VAL_W'($urandom), vel: VAL_W'($urandom),
          acc: VAL_W'($urandom), dec: VAL_W'($urandom), ttc: VAL_W'($urandom)};
    return r;
  endfunction

  task automatic issue(input request_t r);
    start             <= 1'b1;
    operation         <= r.op;
    rule_type         <= r.kind;
    rule_threat       <= r.threat;
    rule_low          <= r.lo;
    rule_high         <= r.hi;
    receiver_id       <= r.rcv;
    channel_mask      <= r.mask;
    distance          <= r.obj_dist;
    velocity          <= r.vel;
    acceleration      <= r.acc;
    decel_to_stop     <= r.dec;
    time_to_collision <= r.ttc;
    do @(posedge clk); while (busy);
    sent++;
    if (!calm && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    request_t                req;
    logic [7:0]              base_rcv;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    int                      n_rules;
    int                      n_objs;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, every rule kind, full table, unused code, clear
    issue(object_req(8'd5, 8'hFF, '0, '0, '0, '0, '0));
    issue(rule_req(KIND_DIST_IN, 3'd3, num(-100), num(100), 8'd5, 8'h01));
    issue(rule_req(KIND_DIST_OUT, 3'd5, num(10), num(20), 8'd5, 8'h02));
    issue(rule_req(KIND_SPEED, 3'd7, NOT_AVAIL, VAL_MAX, 8'd5, 8'h80));
    issue(rule_req(KIND_ACCEL, 3'd6, '0, '0, 8'd5, 8'h04));
    issue(rule_req(KIND_DECEL, 3'd4, num(-5), num(5), 8'd5, 8'h01));
    issue(rule_req(KIND_TTC, 3'd2, num(50), num(-50), 8'd5, 8'h01));
    issue(rule_req(KIND_NONE, 3'd7, NOT_AVAIL, VAL_MAX, 8'd5, 8'hFF));
    issue(rule_req(KIND_SEVEN, 3'd7, NOT_AVAIL, VAL_MAX, 8'd5, 8'hFF));
    issue(rule_req(KIND_DIST_IN, 3'd7, NOT_AVAIL, VAL_MAX, 8'd5, 8'hFF));
    issue(object_req(8'd5, 8'h01, '0, NOT_AVAIL, NOT_AVAIL, NOT_AVAIL, NOT_AVAIL));
    issue(object_req(8'd5, 8'hFF, num(15), NOT_AVAIL, '0, '0, '0));
    issue(object_req(8'd5, 8'h80, '0, VAL_MAX, '0, '0, '0));
    issue(object_req(8'd5, 8'h80, '0, NOT_AVAIL, '0, '0, '0));
    issue(object_req(8'd6, 8'hFF, '0, '0, '0, '0, '0));
    issue(object_req(8'd5, 8'h00, '0, '0, '0, '0, '0));
    issue(object_req(8'd5, 8'h02, NOT_AVAIL, '0, '0, '0, '0));
    req = noise_req();
    req.op = OP_UNUSED;
    issue(req);
    issue(object_req(8'd5, 8'h04, '0, '0, '0, '0, '0));
    issue(blank(OP_CLEAR));
    issue(object_req(8'd5, 8'hFF, '0, '0, '0, '0, '0));
    issue(rule_req(KIND_DIST_OUT, 3'd0, num(1), num(-1), 8'hFF, 8'hFF));
    issue(rule_req(KIND_DIST_OUT, 3'd1, num(1), num(-1), 8'hFF, 8'hFF));
    issue(object_req(8'hFF, 8'h01, VAL_MAX, '0, '0, '0, '0));
    issue(blank(OP_CLEAR));
    drain();

    // random: mostly table build-up followed by objects of the same receivers
    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = (sent >= 500 && sent < 800);
      if ($urandom_range(99) < 80) begin
        base_rcv = 8'($urandom_range(255));
        if ($urandom_range(7) != 0) issue(blank(OP_CLEAR));
        n_rules = $urandom_range(1, 10);
        for (int i = 0; i < n_rules; i++) begin
          a = rand_val();
          b = rand_val();
          if ($urandom_range(3) != 0 && a > b) begin
            req = rule_req(KIND_DIST_IN, 3'd0, b, a, 8'd0, 8'd0);
          end else begin
            req = rule_req(KIND_DIST_IN, 3'd0, a, b, 8'd0, 8'd0);
          end
          req.kind   = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 6));
          req.threat = 3'($urandom_range(7));
          req.rcv    = base_rcv ^ 8'($urandom_range(1));
          req.mask   = ($urandom_range(1) != 0) ? 8'($urandom_range(255)) :
                                                  8'(1 << $urandom_range(7));
          issue(req);
        end
        n_objs = $urandom_range(2, 8);
        for (int i = 0; i < n_objs; i++) begin
          req = object_req(base_rcv ^ 8'($urandom_range(1)), 8'(1 << $urandom_range(7)),
                           rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
          if ($urandom_range(4) == 0) req.mask = 8'($urandom_range(255));
          if ($urandom_range(9) == 0) req.rcv = 8'($urandom_range(255));
          issue(req);
        end
      end else begin
        issue(noise_req());
      end
      if (sent >= 1000 && sent < 1020) drain();
    end

    drain();
    repeat (12) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
